// ----- hw/rtl/hbc_pkg.sv -----
// Shared types and constants for the hashed block buffer cache.
// Used by hbc_mod, the top level and the testbench; depends on nothing.
`default_nettype none

package hbc_pkg;

  localparam int unsigned EntriesDef = 32;
  localparam int unsigned BucketsDef = 13;
  localparam int unsigned BlkW       = 32;
  localparam logic [7:0]  CountMax   = 8'd255;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOBUF  = 2'd1,
    ST_COUNT  = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] now_tick;
  } hbc_req_t;

  typedef struct packed {
    logic [4:0] granted_entry;
    logic       was_hit;
    logic       needs_read;
    logic [1:0] status;
  } hbc_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none

module hbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hbc_mod.sv -----
// Remainder unit: block number modulo the bucket count by reciprocal multiplication.
// Start passes through s1_q and s2_q to done_q. Depends on hbc_pkg.
`default_nettype none

module hbc_mod #(
  parameter int unsigned BUCKETS = 13,
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [hbc_pkg::BlkW-1:0]  blk_i,
  output logic                           done_o,
  output logic      [BW-1:0]             rem_o
);
  import hbc_pkg::*;

  // Rounded-up reciprocal: exact quotient for every 32-bit dividend.
  localparam int unsigned ShL = $clog2(BUCKETS);
  localparam int unsigned MW  = BlkW + 1;
  localparam int unsigned PW  = BlkW + MW;
  localparam logic [63:0] Magic64 =
    ((64'd1 << (BlkW + ShL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [MW-1:0] Magic = Magic64[MW-1:0];

  logic [BlkW-1:0] blk_q;
  logic [PW-1:0]   prod_q, prod_d;
  logic [BW-1:0]   r_q, r_d;
  logic            s1_q, s2_q, done_q;
  logic [PW-1:0]   quo_full;
  logic [BlkW-1:0] quo, qb, diff;

  always_comb begin
    prod_d   = PW'(blk_q) * PW'(Magic);
    quo_full = prod_q >> (BlkW + ShL);
    quo      = quo_full[BlkW-1:0];
    qb       = quo * BlkW'(BUCKETS);
    diff     = blk_q - qb;
    r_d      = diff[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      blk_q <= blk_i;
    end
    if (s1_q) begin
      prod_q <= prod_d;
    end
    if (s2_q) begin
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hashed_block_buffer_cache.sv -----
// Top level of the hashed block buffer cache: sequencer, bucket heads, tag memory.
// Depends on hbc_pkg, hbc_ram and hbc_mod.
//
// Usage. Requests enter on in_valid_i / in_stall_o as an hbc_req_t; each request
// yields exactly one result on out_valid_o / out_stall_i as an hbc_res_t.
// Every tag entry (device, block, valid, count, release time, list link) is one
// word of a single RAM with registered read; the bucket heads are flops.
// One request is processed at a time. Release, pin and unpin read the entry,
// modify and write it, then load the output. A get first computes the
// bucket hash (block number modulo BUCKETS by a reciprocal multiplication), then
// walks its bucket, each entry by a RAM read and then a compare, and closes the
// walk. Without a free entry of its own bucket it walks the other buckets in
// order, again by read and compare, and moves the first free entry it finds
// into its own bucket; with none free anywhere the result is ST_NOBUF.
// After reset the block runs a setup pass that clears all tags and builds the
// bucket lists; in_stall_o stays high during it.
// A finished result sits in the output register; while the receiver stalls it,
// the next request may still be accepted and processed, and its result waits
// until the output register frees.
`default_nettype none

module hashed_block_buffer_cache #(
  parameter int unsigned ENTRIES = hbc_pkg::EntriesDef,
  parameter int unsigned BUCKETS = hbc_pkg::BucketsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hbc_pkg::hbc_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hbc_pkg::hbc_res_t      out_res_o
);
  import hbc_pkg::*;

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned LW   = $clog2(ENTRIES + 1);
  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned BCW  = $clog2(BUCKETS + 1);
  localparam int unsigned Per  = (ENTRIES / BUCKETS > 0) ? ENTRIES / BUCKETS : 1;
  localparam logic [LW-1:0] Nil = LW'(ENTRIES);

  // One RAM word per tag entry.
  typedef struct packed {
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic          valid;
    logic [7:0]    cnt;
    logic [31:0]   tm;
    logic [LW-1:0] link;
  } word_t;

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_PCHK = 12'b0000_0000_0100,
    S_MOD  = 12'b0000_0000_1000,
    S_WALK = 12'b0000_0001_0000,
    S_WCHK = 12'b0000_0010_0000,
    S_OSEL = 12'b0000_0100_0000,
    S_ORD  = 12'b0000_1000_0000,
    S_OCHK = 12'b0001_0000_0000,
    S_OUNL = 12'b0010_0000_0000,
    S_FIN  = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } state_e;

  state_e        state_q, state_d;
  hbc_req_t      req_q, req_d;
  hbc_res_t      res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] cur_q, cur_d, steps_q, steps_d, pick_q, pick_d, prev_q, prev_d;
  logic [LW-1:0] per_q, per_d;
  logic [31:0]   best_q, best_d;
  word_t         pick_w_q, pick_w_d, prev_w_q, prev_w_d;
  logic [BW-1:0] h_q, h_d;
  logic [BCW-1:0] b_q, b_d;
  logic [LW-1:0] head_q [BUCKETS];
  logic [LW-1:0] head_d [BUCKETS];

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  word_t         ram_wdata, ram_rdata;

  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  hbc_ram #(
    .WIDTH($bits(word_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hbc_mod #(
    .BUCKETS(BUCKETS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .blk_i  (in_req_i.block_number),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  logic in_acc, out_acc, walk_end, tag_hit;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign walk_end   = (cur_q >= Nil) || (steps_q >= LW'(ENTRIES));
  assign tag_hit    = (ram_rdata.dev == req_q.device_id) &&
                      (ram_rdata.blk == req_q.block_number);

  always_comb begin
    word_t w;
    w             = ram_rdata;
    state_d       = state_q;
    req_d         = req_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    cur_d         = cur_q;
    steps_d       = steps_q;
    pick_d        = pick_q;
    prev_d        = prev_q;
    per_d         = per_q;
    best_d        = best_q;
    pick_w_d      = pick_w_q;
    prev_w_d      = prev_w_q;
    h_d           = h_q;
    b_d           = b_q;
    head_d        = head_q;
    ram_we        = 1'b0;
    ram_waddr     = cur_q[IW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = cur_q[IW-1:0];
    mod_start     = 1'b0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Setup pass: deal entries round robin into buckets, pushing at each head.
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_wdata.link = head_q[b_q[BW-1:0]];
        head_d[b_q[BW-1:0]] = cur_q;
        cur_d = cur_q + 1'b1;
        if (per_q == LW'(Per - 1)) begin
          per_d = '0;
          b_d   = (b_q == BCW'(BUCKETS - 1)) ? '0 : b_q + 1'b1;
        end else begin
          per_d = per_q + 1'b1;
        end
        if (cur_q == LW'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_d = in_req_i;
          if (in_req_i.req_type == REQ_GET) begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end else if (32'(in_req_i.entry_index) >= 32'(ENTRIES)) begin
            res_d   = '{granted_entry: in_req_i.entry_index, was_hit: 1'b0,
                        needs_read: 1'b0, status: ST_OK};
            state_d = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IW'(in_req_i.entry_index);
            state_d   = S_PCHK;
          end
        end
      end
      // Release, pin and unpin: modify the count of the word just read.
      S_PCHK: begin
        res_d = '{granted_entry: req_q.entry_index, was_hit: 1'b0,
                  needs_read: 1'b0, status: ST_OK};
        ram_waddr = IW'(req_q.entry_index);
        if (req_q.req_type == REQ_PIN) begin
          if (w.cnt >= CountMax) begin
            res_d.status = ST_COUNT;
          end else begin
            w.cnt  = w.cnt + 1'b1;
            ram_we = 1'b1;
          end
        end else begin
          if (w.cnt == '0) begin
            res_d.status = ST_COUNT;
          end else begin
            w.cnt  = w.cnt - 1'b1;
            ram_we = 1'b1;
            if (req_q.req_type == REQ_RELEASE && w.cnt == '0) begin
              w.tm = req_q.now_tick;
            end
          end
        end
        ram_wdata = w;
        state_d   = S_FIN;
      end
      S_MOD: begin
        if (mod_done) begin
          h_d     = mod_rem;
          cur_d   = head_q[mod_rem];
          steps_d = '0;
          pick_d  = Nil;
          best_d  = '1;
          state_d = S_WALK;
        end
      end
      // Own bucket: look for a hit and track the oldest free entry at once.
      S_WALK: begin
        if (walk_end) begin
          if (pick_q != Nil) begin
            ram_we    = 1'b1;
            ram_waddr = pick_q[IW-1:0];
            ram_wdata = pick_w_q;
            ram_wdata.dev   = req_q.device_id;
            ram_wdata.blk   = req_q.block_number;
            ram_wdata.valid = 1'b1;
            ram_wdata.cnt   = 8'd1;
            res_d   = '{granted_entry: 5'(pick_q), was_hit: 1'b0,
                        needs_read: 1'b1, status: ST_OK};
            state_d = S_FIN;
          end else begin
            b_d     = '0;
            state_d = S_OSEL;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (tag_hit) begin
          res_d = '{granted_entry: 5'(cur_q), was_hit: 1'b1,
                    needs_read: !w.valid, status: ST_OK};
          if (w.cnt >= CountMax) begin
            res_d.needs_read = 1'b0;
            res_d.status     = ST_COUNT;
          end else begin
            w.cnt     = w.cnt + 1'b1;
            w.valid   = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = w;
          end
          state_d = S_FIN;
        end else begin
          if (w.cnt == '0 && (pick_q == Nil || w.tm < best_q)) begin
            pick_d   = cur_q;
            pick_w_d = w;
            best_d   = w.tm;
          end
          cur_d   = w.link;
          steps_d = steps_q + 1'b1;
          state_d = S_WALK;
        end
      end
      // Other buckets, lowest first, skipping the own one.
      S_OSEL: begin
        if (b_q >= BCW'(BUCKETS)) begin
          res_d   = '{granted_entry: 5'd0, was_hit: 1'b0,
                      needs_read: 1'b0, status: ST_NOBUF};
          state_d = S_FIN;
        end else if (b_q == BCW'(h_q)) begin
          b_d = b_q + 1'b1;
        end else begin
          cur_d   = head_q[b_q[BW-1:0]];
          prev_d  = Nil;
          steps_d = '0;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        if (walk_end) begin
          b_d     = b_q + 1'b1;
          state_d = S_OSEL;
        end else begin
          ram_re  = 1'b1;
          state_d = S_OCHK;
        end
      end
      // Take the first free entry (unlink it, push it on the own bucket, retag it), else go on.
      S_OCHK: begin
        if (w.cnt == '0) begin
          pick_w_d = w;
          ram_we    = 1'b1;
          ram_wdata = w;
          ram_wdata.dev   = req_q.device_id;
          ram_wdata.blk   = req_q.block_number;
          ram_wdata.valid = 1'b1;
          ram_wdata.cnt   = 8'd1;
          ram_wdata.link  = head_q[h_q];
          head_d[h_q]     = cur_q;
          res_d = '{granted_entry: 5'(cur_q), was_hit: 1'b0,
                    needs_read: 1'b1, status: ST_OK};
          if (prev_q == Nil) begin
            head_d[b_q[BW-1:0]] = w.link;
            state_d = S_FIN;
          end else begin
            state_d = S_OUNL;
          end
        end else begin
          prev_d   = cur_q;
          prev_w_d = w;
          cur_d    = w.link;
          steps_d  = steps_q + 1'b1;
          state_d  = S_ORD;
        end
      end
      S_OUNL: begin
        ram_we    = 1'b1;
        ram_waddr = prev_q[IW-1:0];
        ram_wdata = prev_w_q;
        ram_wdata.link = pick_w_q.link;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      per_q       <= '0;
      b_q         <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_q[i] <= Nil;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      per_q       <= per_d;
      b_q         <= b_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    out_q    <= out_d;
    steps_q  <= steps_d;
    pick_q   <= pick_d;
    prev_q   <= prev_d;
    best_q   <= best_d;
    pick_w_q <= pick_w_d;
    prev_w_q <= prev_w_d;
    h_q      <= h_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_new_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result appeared without a finished request");

  a_other_bucket_not_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OCHK) |-> (b_q != BCW'(h_q)))
    else $error("other-bucket scan visited the own bucket");

  a_nobuf_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && res_q.status == ST_NOBUF) |-> (res_q.granted_entry == 5'd0))
    else $error("no-buffer result carries an entry");

  a_walk_before_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCHK || state_q == S_OCHK) |-> $past(ram_re))
    else $error("compare state entered without a memory read");

endmodule

`default_nettype wire

// ----- test/hashed_block_buffer_cache_test.sv -----
// Self-checking testbench for hashed_block_buffer_cache: a clocked driver and
// monitor around a behavioral copy of the tag store with its bucket lists.
// Depends on hbc_pkg and the hashed_block_buffer_cache RTL.
`timescale 1ns / 1ps

module hashed_block_buffer_cache_test;
  import hbc_pkg::*;

  localparam int unsigned NumEnt = 32;
  localparam int unsigned NumBkt = 13;
  localparam int unsigned NilIdx = NumEnt;
  localparam int unsigned IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hbc_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  hbc_res_t out_res;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hashed_block_buffer_cache i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_res_o(out_res)
  );

  // Behavioral copy of the cache state.
  logic [7:0]  mdl_dev [NumEnt];
  logic [31:0] mdl_blk [NumEnt];
  logic        mdl_vld [NumEnt];
  logic [7:0]  mdl_cnt [NumEnt];
  logic [31:0] mdl_rel [NumEnt];
  int unsigned mdl_link[NumEnt];
  int unsigned mdl_head[NumBkt];

  hbc_req_t pending_reqs[$];
  hbc_res_t expected_res[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_long = 1'b0;
  bit hold_active = 1'b0;
  // Set at the rising edge that takes a request or a result.
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  task automatic cache_reset();
    int unsigned per, e, b, j;
    per = NumEnt / NumBkt;
    if (per == 0) per = 1;
    for (e = 0; e < NumEnt; e++) begin
      mdl_dev[e] = '0; mdl_blk[e] = '0; mdl_vld[e] = 1'b0;
      mdl_cnt[e] = '0; mdl_rel[e] = '0; mdl_link[e] = NilIdx;
    end
    for (b = 0; b < NumBkt; b++) mdl_head[b] = NilIdx;
    e = 0; b = 0;
    while (e < NumEnt) begin
      for (j = 0; j < per && e < NumEnt; j++) begin
        mdl_link[e] = mdl_head[b];
        mdl_head[b] = e;
        e++;
      end
      b = (b + 1) % NumBkt;
    end
  endtask

  function automatic hbc_res_t mk_res(int unsigned ent, bit hit, bit rd, status_e st);
    hbc_res_t r;
    r.granted_entry = ent[4:0];
    r.was_hit = hit;
    r.needs_read = rd;
    r.status = st;
    return r;
  endfunction

  // Unlink entry e from bucket b's list; returns 1 if it was found.
  function automatic bit unlink_from(int unsigned b, int unsigned e);
    int unsigned cur, prev, steps;
    cur = mdl_head[b]; prev = NilIdx; steps = 0;
    while (cur < NumEnt && steps < NumEnt) begin
      if (cur == e) begin
        if (prev == NilIdx) mdl_head[b] = mdl_link[cur];
        else mdl_link[prev] = mdl_link[cur];
        return 1'b1;
      end
      prev = cur; cur = mdl_link[cur]; steps++;
    end
    return 1'b0;
  endfunction

  function automatic hbc_res_t lookup_block(logic [7:0] dev, logic [31:0] blk);
    int unsigned h, cur, steps, pick, b;
    logic [31:0] best;
    bit rd;
    h = blk % NumBkt;
    pick = NilIdx;
    best = 32'hffffffff;
    cur = mdl_head[h];
    for (steps = 0; cur < NumEnt && steps < NumEnt; steps++) begin
      if (mdl_dev[cur] == dev && mdl_blk[cur] == blk) begin
        if (mdl_cnt[cur] >= CountMax) return mk_res(cur, 1'b1, 1'b0, ST_COUNT);
        mdl_cnt[cur]++;
        rd = !mdl_vld[cur];
        mdl_vld[cur] = 1'b1;
        return mk_res(cur, 1'b1, rd, ST_OK);
      end
      cur = mdl_link[cur];
    end
    // Oldest free entry of the home bucket, first one wins ties.
    cur = mdl_head[h];
    for (steps = 0; cur < NumEnt && steps < NumEnt; steps++) begin
      if (mdl_cnt[cur] == 0 && (pick == NilIdx || mdl_rel[cur] < best)) begin
        pick = cur;
        best = mdl_rel[cur];
      end
      cur = mdl_link[cur];
    end
    // Otherwise steal the first free entry of the lowest other bucket that has one.
    for (b = 0; b < NumBkt && pick == NilIdx; b++) begin
      if (b != h) begin
        cur = mdl_head[b];
        for (steps = 0; cur < NumEnt && steps < NumEnt && pick == NilIdx; steps++) begin
          if (mdl_cnt[cur] == 0) pick = cur;
          else cur = mdl_link[cur];
        end
        if (pick != NilIdx && unlink_from(b, pick)) begin
          mdl_link[pick] = mdl_head[h];
          mdl_head[h] = pick;
        end
      end
    end
    if (pick == NilIdx) return mk_res(0, 1'b0, 1'b0, ST_NOBUF);
    mdl_dev[pick] = dev;
    mdl_blk[pick] = blk;
    mdl_cnt[pick] = 8'd1;
    mdl_vld[pick] = 1'b1;
    return mk_res(pick, 1'b0, 1'b1, ST_OK);
  endfunction

  function automatic hbc_res_t apply_request(hbc_req_t rq);
    int unsigned e;
    e = 32'(rq.entry_index);
    if (req_e'(rq.req_type) == REQ_GET) return lookup_block(rq.device_id, rq.block_number);
    if (e >= NumEnt) return mk_res(e, 1'b0, 1'b0, ST_OK);
    if (req_e'(rq.req_type) == REQ_PIN) begin
      if (mdl_cnt[e] >= CountMax) return mk_res(e, 1'b0, 1'b0, ST_COUNT);
      mdl_cnt[e]++;
    end else begin
      if (mdl_cnt[e] == 0) return mk_res(e, 1'b0, 1'b0, ST_COUNT);
      mdl_cnt[e]--;
      if (req_e'(rq.req_type) == REQ_RELEASE && mdl_cnt[e] == 0) mdl_rel[e] = rq.now_tick;
    end
    return mk_res(e, 1'b0, 1'b0, ST_OK);
  endfunction

  function automatic hbc_req_t mk_req(req_e t, logic [7:0] dev, logic [31:0] blk,
                                      logic [4:0] ent, logic [31:0] tick);
    hbc_req_t r;
    r.req_type = t; r.device_id = dev; r.block_number = blk;
    r.entry_index = ent; r.now_tick = tick;
    return r;
  endfunction

  // Driver: presents queued requests at the falling edge after a random gap.
  int unsigned drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // Request taken at the last rising edge.
        in_taken = 1'b0;
        void'(pending_reqs.pop_front());
        drv_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) drv_gap = 0;
      end
      if (drv_gap > 0) begin
        in_valid <= 1'b0;
        drv_gap--;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_req <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction happens at acceptance, in request order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_res.push_back(apply_request(in_req));
      in_taken = 1'b1;
    end
  end

  // Receiver stall: random per result, with one long hold-off on demand.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_long && !hold_active) begin
        hold_active <= 1'b1;
        hold_left = 400;
      end
      if (out_taken) begin
        out_taken = 1'b0;
        stall_left = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    hbc_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      out_taken = 1'b1;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (out_res.granted_entry !== exp_r.granted_entry) begin
          $display("%0t: granted_entry expected %0d actual %0d", $time,
                   exp_r.granted_entry, out_res.granted_entry);
          errors++;
        end
        if (out_res.was_hit !== exp_r.was_hit) begin
          $display("%0t: was_hit expected %0d actual %0d", $time, exp_r.was_hit, out_res.was_hit);
          errors++;
        end
        if (out_res.needs_read !== exp_r.needs_read) begin
          $display("%0t: needs_read expected %0d actual %0d", $time,
                   exp_r.needs_read, out_res.needs_read);
          errors++;
        end
        if (out_res.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_res.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("hashed_block_buffer_cache verification failed");
      $finish;
    end
  end

  // Random request biased toward a small working set so hits, steals and
  // full-cache cases all happen often.
  function automatic hbc_req_t rand_req();
    logic [31:0] blk;
    logic [7:0] dev;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      dev = 8'($urandom_range(0, 3));
      blk = $urandom_range(0, 60);
      if ($urandom_range(0, 9) == 0) blk = $urandom();
      if ($urandom_range(0, 9) == 0) dev = 8'($urandom());
      return mk_req(REQ_GET, dev, blk, 5'($urandom()), $urandom());
    end
    if (k < 80) return mk_req(REQ_RELEASE, 8'($urandom()), $urandom(), 5'($urandom()),
                              $urandom());
    if (k < 90) return mk_req(REQ_PIN, 8'($urandom()), $urandom(), 5'($urandom()),
                              $urandom());
    return mk_req(REQ_UNPIN, 8'($urandom()), $urandom(), 5'($urandom()), $urandom());
  endfunction

  initial begin
    int unsigned i;
    cache_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, each request type and the corner cases.
    pending_reqs.push_back(mk_req(REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_UNPIN, 8'hff, 32'hffffffff, 5'd31, 32'hffffffff));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h00, 32'h0, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h00, 32'h0, 5'd31, 32'hffffffff));
    pending_reqs.push_back(mk_req(REQ_GET, 8'hff, 32'hffffffff, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_PIN, 8'h00, 32'h0, 5'd1, 32'h0));
    pending_reqs.push_back(mk_req(REQ_UNPIN, 8'h00, 32'h0, 5'd1, 32'h0));
    pending_reqs.push_back(mk_req(REQ_RELEASE, 8'h00, 32'h0, 5'd1, 32'hffffffff));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h5a, 32'd13, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_GET, 8'ha5, 32'd26, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h01, 32'd39, 5'd0, 32'h0));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h01, 32'd52, 5'd0, 32'h0));
    // Fill the whole cache until no free buffer remains, then beyond.
    for (i = 0; i < 34; i++)
      pending_reqs.push_back(mk_req(REQ_GET, 8'h10, 32'd100 + i, 5'd0, 32'h0));
    // Entry 27 holds device 0, block 0 from the gets above: saturate it with
    // pins, then hit it at count 255.
    for (i = 0; i < 256; i++)
      pending_reqs.push_back(mk_req(REQ_PIN, 8'h0, 32'h0, 5'd27, 32'h0));
    pending_reqs.push_back(mk_req(REQ_GET, 8'h00, 32'h0, 5'd0, 32'h0));
    // Release every entry once with mixed ticks, including the maximum.
    for (i = 0; i < 32; i++)
      pending_reqs.push_back(mk_req(REQ_RELEASE, 8'h0, 32'h0, 5'(i), (i % 3 == 0) ?
                                    32'hffffffff : $urandom()));
    wait (pending_reqs.size() == 0);

    // Long receiver hold-off while requests keep coming.
    hold_long = 1'b1;
    for (i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0);

    for (i = 0; i < 975; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0 && !(in_valid && !in_stall));
    wait (expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("hashed_block_buffer_cache verification clean");
    end else begin
      $display("hashed_block_buffer_cache verification failed");
    end
    $finish;
  end

endmodule
